### rtl/core/cmt_pkg.sv
// shared types and constants for the counted multiset table
// no dependencies; used by every module in rtl/core
package cmt_pkg;

    localparam int ENTRIES     = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int DIST_W      = $clog2(ENTRIES + 1);
    localparam int OCC_W       = 16;
    localparam int DK_W        = 5;
    localparam int ST_W        = 2;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_ERASE_ONE,
        CMD_ERASE_ALL,
        CMD_QUERY
    } command_t;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        command_t           command;
        logic signed [31:0] key;
    } in_word_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [OCC_W-1:0] occurrences;
        logic [DK_W-1:0]  distinct_keys;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_sts_t;

endpackage

### rtl/core/counted_multiset_table_top.sv
// a word accepted is scanned against every slot, then the table is updated and the result registered
// one word in flight at a time: the next is accepted only after the table update of the last one
// a result waits in the output register while the next word is accepted and scanned
// reset: synchronous active-low aresetn empties all slots and clears the key total
// top level of the counted multiset table: controller plus datapath
// depends on cmt_pkg, cmt_ctrl, cmt_datapath
module counted_multiset_table_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cmt_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cmt_pkg::out_word_t m_data
);

    cmt_pkg::dp_cmd_t dp_cmd;
    cmt_pkg::dp_sts_t dp_sts;

    cmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (dp_cmd),
        .sts     (dp_sts)
    );

    cmt_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (dp_cmd),
        .sts     (dp_sts),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word accepted while another is in flight");

    a_no_commit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_sts.scan_done |-> !dp_cmd.commit && !s_ready)
        else $error("scan end overlaps commit or accept");

    a_full_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == cmt_pkg::ST_FULL
        |-> m_data.distinct_keys == cmt_pkg::DK_W'(cmt_pkg::ENTRIES))
        else $error("full status with free slots");

    a_missing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == cmt_pkg::ST_MISSING |-> m_data.occurrences == '0)
        else $error("missing key reports occurrences");
`endif

endmodule

### rtl/core/cmt_ctrl.sv
// sequencing state machine: accept, key scan, table update and result handoff
// depends on cmt_pkg
module cmt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output cmt_pkg::dp_cmd_t  cmd,
    input  cmt_pkg::dp_sts_t  sts
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   s_ready_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.scan_en = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done) begin
                    state_next = UPDATE;
                end
            end
            UPDATE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
        s_ready_next = (state_next == IDLE);
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

### rtl/core/cmt_datapath.sv
// key memory, count table, scan comparator, update logic and result register
// depends on cmt_pkg
module cmt_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmt_pkg::in_word_t  s_data,
    input  cmt_pkg::dp_cmd_t   cmd,
    output cmt_pkg::dp_sts_t   sts,
    output cmt_pkg::out_word_t m_data
);

    logic [cmt_pkg::KEY_W-1:0]       key_mem [cmt_pkg::ENTRIES];
    logic [cmt_pkg::COUNT_WIDTH-1:0] count_reg [cmt_pkg::ENTRIES];

    cmt_pkg::command_t               cmd_reg;
    logic [cmt_pkg::KEY_W-1:0]       key_reg;
    logic [cmt_pkg::IDX_W-1:0]       scan_idx_reg;
    logic                            issue_reg;
    logic                            cmp_valid_reg;
    logic [cmt_pkg::IDX_W-1:0]       cmp_idx_reg;
    logic [cmt_pkg::KEY_W-1:0]       key_q_reg;
    logic                            hit_reg;
    logic [cmt_pkg::IDX_W-1:0]       hit_idx_reg;
    logic [cmt_pkg::COUNT_WIDTH-1:0] hit_cnt_reg;
    logic                            free_reg;
    logic [cmt_pkg::IDX_W-1:0]       free_idx_reg;
    logic [cmt_pkg::DIST_W-1:0]      dist_reg;
    cmt_pkg::out_word_t              out_reg;

    logic [cmt_pkg::COUNT_WIDTH-1:0] cmp_cnt;
    logic                            cmp_hit;
    logic                            cmp_free;

    logic                            wr_en;
    logic                            key_we;
    logic [cmt_pkg::IDX_W-1:0]       wr_idx;
    logic [cmt_pkg::COUNT_WIDTH-1:0] wr_cnt;
    logic [cmt_pkg::DIST_W-1:0]      dist_next;
    logic [cmt_pkg::ST_W-1:0]        st_next;
    logic [cmt_pkg::COUNT_WIDTH-1:0] occ_cnt;
    logic [cmt_pkg::OCC_W+cmt_pkg::COUNT_WIDTH-1:0] occ_wide;
    logic [cmt_pkg::DK_W+cmt_pkg::DIST_W-1:0]       dist_wide;

    // compare stage, one entry per cycle
    assign cmp_cnt  = count_reg[cmp_idx_reg];
    assign cmp_hit  = cmp_valid_reg && (cmp_cnt != '0) && (key_q_reg == key_reg);
    assign cmp_free = cmp_valid_reg && (cmp_cnt == '0);

    assign sts.scan_done = cmp_valid_reg
        && (cmp_idx_reg == cmt_pkg::IDX_W'(cmt_pkg::ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end else if (cmd.load) begin
            issue_reg     <= 1'b1;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            if (cmd.scan_en && issue_reg) begin
                cmp_valid_reg <= 1'b1;
                if (scan_idx_reg == cmt_pkg::IDX_W'(cmt_pkg::ENTRIES - 1)) begin
                    issue_reg <= 1'b0;
                end
            end else begin
                cmp_valid_reg <= 1'b0;
            end
            if (cmp_hit && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (cmp_free && !free_reg) begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg      <= s_data.command;
            key_reg      <= s_data.key;
            scan_idx_reg <= '0;
        end else if (cmd.scan_en && issue_reg) begin
            scan_idx_reg <= scan_idx_reg + cmt_pkg::IDX_W'(1);
        end
        cmp_idx_reg <= scan_idx_reg;
        if (cmp_hit && !hit_reg) begin
            hit_idx_reg <= cmp_idx_reg;
            hit_cnt_reg <= cmp_cnt;
        end
        if (cmp_free && !free_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && key_we) begin
            key_mem[free_idx_reg] <= key_reg;
        end
        key_q_reg <= key_mem[scan_idx_reg];
    end

    always_comb begin
        wr_en     = 1'b0;
        key_we    = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_cnt    = hit_cnt_reg;
        dist_next = dist_reg;
        st_next   = cmt_pkg::ST_OK;
        occ_cnt   = '0;
        if (cmd_reg == cmt_pkg::CMD_INSERT) begin
            if (hit_reg) begin
                if (hit_cnt_reg != cmt_pkg::COUNT_MAX) begin
                    wr_en  = 1'b1;
                    wr_cnt = hit_cnt_reg + cmt_pkg::COUNT_WIDTH'(1);
                end
            end else if (free_reg) begin
                wr_en     = 1'b1;
                key_we    = 1'b1;
                wr_idx    = free_idx_reg;
                wr_cnt    = cmt_pkg::COUNT_WIDTH'(1);
                dist_next = dist_reg + cmt_pkg::DIST_W'(1);
            end else begin
                st_next = cmt_pkg::ST_FULL;
            end
        end else if (!hit_reg) begin
            st_next = cmt_pkg::ST_MISSING;
        end else begin
            case (cmd_reg)
                cmt_pkg::CMD_ERASE_ONE: begin
                    wr_en  = 1'b1;
                    wr_cnt = hit_cnt_reg - cmt_pkg::COUNT_WIDTH'(1);
                    if (hit_cnt_reg == cmt_pkg::COUNT_WIDTH'(1)) begin
                        dist_next = dist_reg - cmt_pkg::DIST_W'(1);
                    end
                end
                cmt_pkg::CMD_ERASE_ALL: begin
                    wr_en     = 1'b1;
                    wr_cnt    = '0;
                    occ_cnt   = hit_cnt_reg;
                    dist_next = dist_reg - cmt_pkg::DIST_W'(1);
                end
                default: begin
                    occ_cnt = hit_cnt_reg;
                end
            endcase
        end
        occ_wide  = {{cmt_pkg::OCC_W{1'b0}}, occ_cnt};
        dist_wide = {{cmt_pkg::DK_W{1'b0}}, dist_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cmt_pkg::ENTRIES; i++) begin
                count_reg[i] <= '0;
            end
            dist_reg <= '0;
        end else if (cmd.commit) begin
            if (wr_en) begin
                count_reg[wr_idx] <= wr_cnt;
            end
            dist_reg <= dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg.status        <= st_next;
            out_reg.occurrences   <= occ_wide[cmt_pkg::OCC_W-1:0];
            out_reg.distinct_keys <= dist_wide[cmt_pkg::DK_W-1:0];
        end
    end

    assign m_data = out_reg;

endmodule

### tb/sv/tb_counted_multiset_table_top.sv
// self-checking testbench for counted_multiset_table_top: directed and random words
// predicts every result from its own model of the table; depends on cmt_pkg and the rtl top
module tb_counted_multiset_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 6_000_000;
    localparam int  POOL_SIZE   = 24;
    localparam int  HOLD_CYCLES = 400;
    localparam int  RAND_WORDS  = 1950;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        cmt_pkg::in_word_t word;
        bit                paced;
    } stim_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cmt_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    cmt_pkg::out_word_t m_data;

    stim_t              stim_words[$];
    cmt_pkg::out_word_t expected_results[$];
    cmt_pkg::out_word_t want;
    stim_t              next_item;

    logic signed [31:0]              tbl_keys   [cmt_pkg::ENTRIES];
    logic [cmt_pkg::COUNT_WIDTH-1:0] tbl_counts [cmt_pkg::ENTRIES];
    int                              tbl_distinct;

    logic signed [31:0] key_pool[POOL_SIZE];

    int  cycles = 0;
    int  mismatches = 0;
    int  n_checked = 0;
    int  n_full = 0;
    int  n_missing = 0;
    int  n_accepted = 0;
    bit  s_taken = 1'b0;
    int  gap_left = 0;
    int  burst_left = 0;
    bit  hold_go = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;
    int  stall_pct = 0;
    int  stall_phase_left = 0;

    counted_multiset_table_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic cmt_pkg::out_word_t multiset_apply(cmt_pkg::in_word_t w);
        cmt_pkg::out_word_t r;
        int hit;
        int vacant;
        r = '0;
        hit = -1;
        vacant = -1;
        for (int i = 0; i < cmt_pkg::ENTRIES; i++) begin
            if (hit < 0 && tbl_counts[i] != '0 && tbl_keys[i] == w.key) hit = i;
            if (vacant < 0 && tbl_counts[i] == '0) vacant = i;
        end
        r.status = cmt_pkg::ST_OK;
        if (w.command == cmt_pkg::CMD_INSERT) begin
            if (hit >= 0) begin
                if (tbl_counts[hit] != cmt_pkg::COUNT_MAX)
                    tbl_counts[hit] = tbl_counts[hit] + 1'b1;
            end else if (vacant < 0) begin
                r.status = cmt_pkg::ST_FULL;
                n_full++;
            end else begin
                tbl_keys[vacant]   = w.key;
                tbl_counts[vacant] = cmt_pkg::COUNT_WIDTH'(1);
                tbl_distinct++;
            end
        end else if (hit < 0) begin
            r.status = cmt_pkg::ST_MISSING;
            n_missing++;
        end else begin
            case (w.command)
                cmt_pkg::CMD_ERASE_ONE: begin
                    tbl_counts[hit] = tbl_counts[hit] - 1'b1;
                    if (tbl_counts[hit] == '0) tbl_distinct--;
                end
                cmt_pkg::CMD_ERASE_ALL: begin
                    r.occurrences   = cmt_pkg::OCC_W'(tbl_counts[hit]);
                    tbl_counts[hit] = '0;
                    tbl_distinct--;
                end
                default: begin
                    r.occurrences = cmt_pkg::OCC_W'(tbl_counts[hit]);
                end
            endcase
        end
        r.distinct_keys = cmt_pkg::DK_W'(tbl_distinct);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, exp_v);
        mismatches++;
    endtask

    task automatic send(input cmt_pkg::command_t cmd, input logic signed [31:0] key,
                        input bit paced);
        stim_t it;
        it.word.command = cmd;
        it.word.key     = key;
        it.paced        = paced;
        stim_words.push_back(it);
    endtask

    task automatic wait_idle();
        while (stim_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        int span;
        int ins_w;
        int r;
        cmt_pkg::command_t cmd;
        logic signed [31:0] key;
        span = POOL_SIZE;
        ins_w = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 75 == 0) begin
                span  = $urandom_range(3, POOL_SIZE);
                ins_w = $urandom_range(20, 75);
            end
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                cmd = cmt_pkg::CMD_INSERT;
            end else begin
                r = $urandom_range(0, 99);
                cmd = (r < 45) ? cmt_pkg::CMD_ERASE_ONE :
                      (r < 65) ? cmt_pkg::CMD_ERASE_ALL : cmt_pkg::CMD_QUERY;
            end
            key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
            send(cmd, key, 1'b1);
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (stim_words.size() > 0) begin
            next_item = stim_words.pop_front();
            s_valid <= 1'b1;
            s_data  <= next_item.word;
            if (next_item.paced) begin
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (stall_phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
                stall_phase_left = $urandom_range(16, 128);
            end else begin
                stall_phase_left--;
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        cycles++;
        s_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(multiset_apply(s_data));
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing pending", m_data, 0);
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.occurrences !== want.occurrences)
                        report_mismatch("occurrences", m_data.occurrences, want.occurrences);
                    if (m_data.distinct_keys !== want.distinct_keys)
                        report_mismatch("distinct_keys", m_data.distinct_keys,
                                        want.distinct_keys);
                end
            end
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still pending", cycles,
                 expected_results.size());
        $display("FAIL counted_multiset_table_top");
        $finish;
    end

    initial begin
        for (int i = 0; i < cmt_pkg::ENTRIES; i++) begin
            tbl_keys[i]   = '0;
            tbl_counts[i] = '0;
        end
        tbl_distinct = 0;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        key_pool[4] = $urandom;
        key_pool[5] = key_pool[4] ^ 32'h0000_0001;
        key_pool[6] = key_pool[4] ^ 32'h8000_0000;
        for (int i = 7; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // missing keys on an empty table, extremes, fill to full
        send(cmt_pkg::CMD_QUERY, '0, 1'b1);
        send(cmt_pkg::CMD_ERASE_ONE, '0, 1'b1);
        send(cmt_pkg::CMD_ERASE_ALL, '0, 1'b1);
        send(cmt_pkg::CMD_INSERT, KEY_MIN, 1'b1);
        send(cmt_pkg::CMD_INSERT, KEY_MAX, 1'b1);
        send(cmt_pkg::CMD_INSERT, '0, 1'b1);
        send(cmt_pkg::CMD_INSERT, -1, 1'b1);
        send(cmt_pkg::CMD_INSERT, KEY_MAX, 1'b1);
        send(cmt_pkg::CMD_QUERY, KEY_MAX, 1'b1);
        send(cmt_pkg::CMD_QUERY, KEY_MAX ^ 32'h1, 1'b1);
        send(cmt_pkg::CMD_ERASE_ONE, KEY_MAX, 1'b1);
        send(cmt_pkg::CMD_ERASE_ALL, KEY_MAX, 1'b1);
        send(cmt_pkg::CMD_ERASE_ONE, KEY_MIN, 1'b1);
        for (int i = 1; i <= 14; i++) send(cmt_pkg::CMD_INSERT, i * 32'h1111_1111, 1'b1);
        send(cmt_pkg::CMD_INSERT, KEY_MIN, 1'b1);
        send(cmt_pkg::CMD_QUERY, KEY_MIN, 1'b1);
        send(cmt_pkg::CMD_ERASE_ALL, 32'h1111_1111, 1'b1);
        send(cmt_pkg::CMD_INSERT, KEY_MIN, 1'b1);
        wait_idle();

        // random traffic, with one long receiver hold while the sender keeps going
        send_random(700);
        while (stim_words.size() > 500) @(posedge aclk);
        hold_go = 1'b1;
        wait_idle();
        send_random(RAND_WORDS - 700);
        wait_idle();
        repeat (cmt_pkg::ENTRIES + 8) @(posedge aclk);

        $display("run covered %0d words, %0d results checked, %0d mismatches", n_accepted,
                 n_checked, mismatches);
        $display("table-full drops %0d, missing-key results %0d, one long receiver hold",
                 n_full, n_missing);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS counted_multiset_table_top");
        end else begin
            $display("FAIL counted_multiset_table_top");
        end
        $finish;
    end

endmodule
